### hdl/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg - shared definitions for the serial frame command decoder
// Frame header bytes, payload positions, command ranges, divider constants,
// the parser phase type and the frame record passed from front to back.
// ----------------------------------------------------------------------------
package sfcd_pkg;

	// Frame format
	localparam int unsigned BUF_DEPTH   = 16;
	localparam logic [7:0]  HDR_FIRST   = 8'h5A;
	localparam logic [7:0]  HDR_SECOND  = 8'hA5;
	localparam int unsigned CMD_POS     = 2;
	localparam int unsigned VAL_HI_POS  = 4;
	localparam int unsigned VAL_LO_POS  = 5;
	localparam logic [7:0]  STORE_RESET = 8'hFF;

	// Command map
	localparam logic [7:0] CMD_SLOT_FIRST   = 8'h01;
	localparam logic [7:0] CMD_SLOT_LAST    = 8'h19;
	localparam logic [7:0] CMD_MANUAL_FIRST = 8'h23;
	localparam logic [7:0] CMD_MANUAL_LAST  = 8'h28;
	localparam logic [3:0] SLOT_SIG_METER   = 4'd0;
	localparam logic [3:0] SLOT_MANUAL      = 4'd13;
	localparam logic [3:0] SLOT_UNKNOWN     = 4'd14;

	// max_signal = SIG_SCALE * value / 1000 - SIG_OFFSET
	// 1000 = 8 * 125: shift by 3, then multiply by a reciprocal of 125.
	localparam int unsigned SIG_SCALE     = 65535;
	localparam int unsigned SIG_OFFSET    = 2000;
	localparam int unsigned DIV_PRE_SHIFT = 3;
	localparam int unsigned DIV_ODD       = 125;
	localparam int unsigned SCALED_W      = 32;
	localparam int unsigned QIN_W         = SCALED_W - DIV_PRE_SHIFT;
	localparam int unsigned RECIP_SHIFT   = QIN_W + 7;
	localparam int unsigned RECIP_W       = 30;
	localparam logic [RECIP_W-1:0] RECIP_MULT =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));
	localparam int unsigned PROD_W        = QIN_W + RECIP_W;
	localparam int unsigned QUO_W         = 23;
	localparam int unsigned SIG_W         = 24;

	// Queue between parser and decoder
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HDR2,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [7:0]  cmd;
		logic [15:0] value;
	} frame_rec_t;

	typedef struct packed {
		logic       valid;
		frame_rec_t rec;
	} frame_push_t;

	// Command byte to parameter slot
	function automatic logic [3:0] map_slot(input logic [7:0] cmd);
		logic [7:0] idx;
		idx = (cmd - CMD_SLOT_FIRST) >> 1;
		if (cmd[0] && cmd >= CMD_SLOT_FIRST && cmd <= CMD_SLOT_LAST)
			return idx[3:0];
		else if (cmd >= CMD_MANUAL_FIRST && cmd <= CMD_MANUAL_LAST)
			return SLOT_MANUAL;
		else
			return SLOT_UNKNOWN;
	endfunction

endpackage

### hdl/sfcd_front.sv
// ----------------------------------------------------------------------------
// sfcd_front - frame parser
// Hunts for the two header bytes, takes the length, counts payload bytes and
// keeps the command and value bytes. Pushes one record per completed frame.
// ----------------------------------------------------------------------------
module sfcd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	input  logic                 fifo_full,
	output sfcd_pkg::frame_push_t push
);

	sfcd_pkg::phase_t phase_q, phase_d;
	logic [7:0] len_q;
	logic [7:0] cnt_q;
	logic [7:0] cnt_inc;
	logic [7:0] cmd_q, hi_q, lo_q;
	logic       accept;
	logic       done;
	logic       in_data;
	logic       wr_cmd, wr_hi, wr_lo;

	assign in_stall = fifo_full;
	assign accept   = in_valid && !in_stall;
	assign cnt_inc  = cnt_q + 8'd1;
	assign in_data  = accept && (phase_q == sfcd_pkg::PH_DATA);

	// Store writes for the only positions the decoder looks at
	assign wr_cmd = in_data && (cnt_q == 8'(sfcd_pkg::CMD_POS))
		&& (sfcd_pkg::CMD_POS < sfcd_pkg::BUF_DEPTH);
	assign wr_hi  = in_data && (cnt_q == 8'(sfcd_pkg::VAL_HI_POS))
		&& (sfcd_pkg::VAL_HI_POS < sfcd_pkg::BUF_DEPTH);
	assign wr_lo  = in_data && (cnt_q == 8'(sfcd_pkg::VAL_LO_POS))
		&& (sfcd_pkg::VAL_LO_POS < sfcd_pkg::BUF_DEPTH);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		done    = 1'b0;
		unique case (phase_q)
			sfcd_pkg::PH_HUNT: begin
				if (rx_byte == sfcd_pkg::HDR_FIRST)
					phase_d = sfcd_pkg::PH_HDR2;
			end
			sfcd_pkg::PH_HDR2: begin
				phase_d = (rx_byte == sfcd_pkg::HDR_SECOND) ?
					sfcd_pkg::PH_LEN : sfcd_pkg::PH_HUNT;
			end
			sfcd_pkg::PH_LEN: begin
				phase_d = sfcd_pkg::PH_DATA;
			end
			sfcd_pkg::PH_DATA: begin
				if (cnt_inc >= len_q) begin
					phase_d = sfcd_pkg::PH_HUNT;
					done    = 1'b1;
				end
			end
			default: phase_d = sfcd_pkg::PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= sfcd_pkg::PH_HUNT;
		else if (accept)
			phase_q <= phase_d;
	end

	// Length and payload counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 8'd0;
			cnt_q <= 8'd0;
		end else if (accept && phase_q == sfcd_pkg::PH_LEN) begin
			len_q <= rx_byte;
			cnt_q <= 8'd0;
		end else if (in_data) begin
			cnt_q <= cnt_inc;
		end
	end

	// Kept payload bytes; earlier contents persist across short frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= sfcd_pkg::STORE_RESET;
			hi_q  <= sfcd_pkg::STORE_RESET;
			lo_q  <= sfcd_pkg::STORE_RESET;
		end else begin
			if (wr_cmd)
				cmd_q <= rx_byte;
			if (wr_hi)
				hi_q <= rx_byte;
			if (wr_lo)
				lo_q <= rx_byte;
		end
	end

	// Record for a completed frame, bypassing the byte written this cycle
	always_comb begin
		push.valid           = accept && done;
		push.rec.cmd         = wr_cmd ? rx_byte : cmd_q;
		push.rec.value[15:8] = wr_hi ? rx_byte : hi_q;
		push.rec.value[7:0]  = wr_lo ? rx_byte : lo_q;
	end

endmodule

### hdl/sfcd_fifo.sv
// ----------------------------------------------------------------------------
// sfcd_fifo - frame record queue
// Small register queue between parser and decoder so each side stalls on
// its own.
// ----------------------------------------------------------------------------
module sfcd_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sfcd_pkg::frame_push_t push,
	input  logic                  pop,
	output sfcd_pkg::frame_rec_t  rd_rec,
	output logic                  full,
	output logic                  empty
);

	sfcd_pkg::frame_rec_t mem_q [sfcd_pkg::FIFO_DEPTH];
	logic [sfcd_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [sfcd_pkg::FIFO_AW:0]   count_q;
	logic                         do_push, do_pop;

	assign full    = (count_q == (sfcd_pkg::FIFO_AW+1)'(sfcd_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign rd_rec  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.rec;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### hdl/sfcd_back.sv
// ----------------------------------------------------------------------------
// sfcd_back - command decoder pipeline
// Maps the command to a slot and works out the scaled signal limit over two
// stages, then holds the result in an output register until taken.
// ----------------------------------------------------------------------------
module sfcd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfcd_pkg::frame_rec_t        rd_rec,
	input  logic                        empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [3:0]                  target_slot,
	output logic [7:0]                  command_code,
	output logic [15:0]                 param_value,
	output logic signed [sfcd_pkg::SIG_W-1:0] max_signal
);

	logic                              adv;
	logic [sfcd_pkg::SCALED_W-1:0]     scaled;
	logic [sfcd_pkg::PROD_W-1:0]       prod;
	logic [sfcd_pkg::QUO_W-1:0]        quo;
	logic signed [sfcd_pkg::SIG_W-1:0] sig;

	logic                          valid_s1;
	logic [7:0]                    cmd_s1;
	logic [15:0]                   val_s1;
	logic [3:0]                    slot_s1;
	logic [sfcd_pkg::QIN_W-1:0]    qin_s1;

	logic                          valid_s2;
	logic [7:0]                    cmd_s2;
	logic [15:0]                   val_s2;
	logic [3:0]                    slot_s2;
	logic [sfcd_pkg::PROD_W-1:0]   prod_s2;

	logic                          valid_q;
	logic [3:0]                    slot_q;
	logic [7:0]                    cmd_q;
	logic [15:0]                   val_q;
	logic signed [sfcd_pkg::SIG_W-1:0] sig_q;

	// Whole pipeline moves when the output slot is free or being taken
	assign adv = !valid_q || !out_stall;
	assign pop = adv && !empty;

	// Stage 1: scale by 65535 and drop the factor of 8
	assign scaled = sfcd_pkg::SCALED_W'(rd_rec.value) * sfcd_pkg::SCALED_W'(sfcd_pkg::SIG_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= !empty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1  <= rd_rec.cmd;
			val_s1  <= rd_rec.value;
			slot_s1 <= sfcd_pkg::map_slot(rd_rec.cmd);
			qin_s1  <= scaled[sfcd_pkg::SCALED_W-1:sfcd_pkg::DIV_PRE_SHIFT];
		end
	end

	// Stage 2: reciprocal multiply for the divide by 125
	assign prod = sfcd_pkg::PROD_W'(qin_s1) * sfcd_pkg::PROD_W'(sfcd_pkg::RECIP_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2  <= cmd_s1;
			val_s2  <= val_s1;
			slot_s2 <= slot_s1;
			prod_s2 <= prod;
		end
	end

	// Output: quotient minus offset, only for the signals-per-meter slot
	assign quo = prod_s2[sfcd_pkg::RECIP_SHIFT +: sfcd_pkg::QUO_W];
	assign sig = (slot_s2 == sfcd_pkg::SLOT_SIG_METER) ?
		sfcd_pkg::SIG_W'(quo) - sfcd_pkg::SIG_W'(sfcd_pkg::SIG_OFFSET) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_q <= slot_s2;
			cmd_q  <= cmd_s2;
			val_q  <= val_s2;
			sig_q  <= sig;
		end
	end

	assign out_valid    = valid_q;
	assign target_slot  = slot_q;
	assign command_code = cmd_q;
	assign param_value  = val_q;
	assign max_signal   = sig_q;

endmodule

### hdl/serial_frame_command_decoder.sv
// ----------------------------------------------------------------------------
// serial_frame_command_decoder - length-prefixed serial frame parser
// Parses 0x5A 0xA5 <len> <payload> frames and decodes the command and value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte per
//   transaction, one byte every cycle while in_stall is low. The parser
//   updates its phase in a single step per byte.
//   Output channel (out_valid / out_stall / result fields) gives one
//   transaction per completed frame; bytes that do not finish a frame give
//   nothing.
//   A completed frame passes through the record queue, the scale stage, the
//   multiply stage and the output register before it shows on out_valid.
//   Throughput is one byte per cycle in while in_stall is low and one result
//   per cycle out while out_stall is low.
//   A four-entry record queue sits between parser and decoder. When out_stall
//   holds, the decoder pipeline freezes, the queue fills, and in_stall rises
//   only once the queue holds four completed frames.
//   Reset (arst_n low) returns the parser to header hunting, clears the
//   queue and pipeline, and sets the kept command and value bytes to 0xFF.
// ----------------------------------------------------------------------------
module serial_frame_command_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  target_slot,
	output logic [7:0]  command_code,
	output logic [15:0] param_value,
	output logic signed [23:0] max_signal
);

	sfcd_pkg::frame_push_t push;
	sfcd_pkg::frame_rec_t  rd_rec;
	logic                  fifo_full;
	logic                  fifo_empty;
	logic                  pop;

	sfcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.fifo_full (fifo_full),
		.push      (push)
	);

	sfcd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.rd_rec (rd_rec),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	sfcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_rec       (rd_rec),
		.empty        (fifo_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.target_slot  (target_slot),
		.command_code (command_code),
		.param_value  (param_value),
		.max_signal   (max_signal)
	);

endmodule

### hdl/sfcd_chk.sv
// ----------------------------------------------------------------------------
// sfcd_chk - port-level checks for the serial frame command decoder
// Watches the output channel for handshake and decode consistency.
// ----------------------------------------------------------------------------
module sfcd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  target_slot,
	input logic [7:0]  command_code,
	input logic [15:0] param_value,
	input logic signed [23:0] max_signal
);

	// Stalled result transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target_slot)
		&& $stable(command_code) && $stable(param_value) && $stable(max_signal))
		else $error("output transaction changed while stalled");

	// Signal limit only for the signals-per-meter slot
	a_sig_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target_slot != sfcd_pkg::SLOT_SIG_METER |-> max_signal == 24'sd0)
		else $error("max_signal nonzero outside slot 0");

	// Slot 0 comes only from its own command
	a_slot0_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target_slot == sfcd_pkg::SLOT_SIG_METER
		|-> command_code == sfcd_pkg::CMD_SLOT_FIRST)
		else $error("slot 0 with wrong command");

	// Manual slot matches the manual command range
	a_manual_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target_slot == sfcd_pkg::SLOT_MANUAL
		|-> command_code >= sfcd_pkg::CMD_MANUAL_FIRST
		&& command_code <= sfcd_pkg::CMD_MANUAL_LAST)
		else $error("manual slot outside manual command range");

endmodule

bind serial_frame_command_decoder sfcd_chk u_sfcd_chk (.*);

### sim/serial_frame_command_decoder_tb.sv
// ----------------------------------------------------------------------------
// serial_frame_command_decoder_tb - frame parser and command decoder check
// Feeds header, length and payload byte streams with random gaps on the input
// side and random stalls on the output side. A scoreboard tracks the parser
// phase and the payload bytes, decodes every completed frame into slot,
// command, value and scaled signal count, and checks the results in order.
// ----------------------------------------------------------------------------
module serial_frame_command_decoder_tb;

	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned RAND_BYTES = 240;
	localparam int unsigned RAND_FRAMES = 10;
	localparam int unsigned QUIET_AFTER = 200;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned STORE_AW = $clog2(sfcd_pkg::BUF_DEPTH);

	typedef struct packed {
		logic [3:0]  slot;
		logic [7:0]  cmd;
		logic [15:0] value;
		logic [23:0] sig;
	} frame_result_t;

	// Tracks the parser and holds decoded results still owed by the block
	class frame_scoreboard;
		sfcd_pkg::phase_t phase;
		logic [7:0]    frame_len;
		logic [7:0]    byte_cnt;
		logic [7:0]    store [sfcd_pkg::BUF_DEPTH];
		frame_result_t expected_results [$];
		int            errors;
		int            frames_seen;

		function new();
			phase = sfcd_pkg::PH_HUNT;
			frame_len = 8'd0;
			byte_cnt = 8'd0;
			foreach (store[i])
				store[i] = sfcd_pkg::STORE_RESET;
			errors = 0;
			frames_seen = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// One accepted input byte; a finished frame queues its decode
		function void take_byte(logic [7:0] b);
			frame_result_t r;
			logic [7:0]    offs;
			longint        scaled;
			case (phase)
				sfcd_pkg::PH_HUNT: begin
					if (b == sfcd_pkg::HDR_FIRST)
						phase = sfcd_pkg::PH_HDR2;
				end
				sfcd_pkg::PH_HDR2: begin
					phase = (b == sfcd_pkg::HDR_SECOND) ?
						sfcd_pkg::PH_LEN : sfcd_pkg::PH_HUNT;
				end
				sfcd_pkg::PH_LEN: begin
					frame_len = b;
					byte_cnt = 8'd0;
					phase = sfcd_pkg::PH_DATA;
				end
				default: begin
					if (byte_cnt < sfcd_pkg::BUF_DEPTH)
						store[byte_cnt[STORE_AW-1:0]] = b;
					byte_cnt = byte_cnt + 8'd1;
					if (byte_cnt >= frame_len) begin
						phase = sfcd_pkg::PH_HUNT;
						r.cmd = store[sfcd_pkg::CMD_POS];
						r.value = {store[sfcd_pkg::VAL_HI_POS], store[sfcd_pkg::VAL_LO_POS]};
						// odd commands in the slot range index slots, then manual, else unknown
						offs = r.cmd - sfcd_pkg::CMD_SLOT_FIRST;
						if (r.cmd[0] && r.cmd >= sfcd_pkg::CMD_SLOT_FIRST &&
						    r.cmd <= sfcd_pkg::CMD_SLOT_LAST)
							r.slot = offs[4:1];
						else if (r.cmd >= sfcd_pkg::CMD_MANUAL_FIRST &&
						         r.cmd <= sfcd_pkg::CMD_MANUAL_LAST)
							r.slot = sfcd_pkg::SLOT_MANUAL;
						else
							r.slot = sfcd_pkg::SLOT_UNKNOWN;
						r.sig = '0;
						if (r.slot == sfcd_pkg::SLOT_SIG_METER) begin
							scaled = (longint'(sfcd_pkg::SIG_SCALE) * longint'(r.value)) / 1000
								- longint'(sfcd_pkg::SIG_OFFSET);
							r.sig = scaled[23:0];
						end
						expected_results.push_back(r);
						frames_seen++;
					end
				end
			endcase
		endfunction

		// One accepted result against the oldest expectation
		function void check_result(frame_result_t got);
			frame_result_t exp_r;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t unexpected result: slot=%0d cmd=%02h value=%04h sig=%0d",
						$realtime, got.slot, got.cmd, got.value, $signed(got.sig));
				return;
			end
			exp_r = expected_results.pop_front();
			if (got.slot !== exp_r.slot || got.cmd !== exp_r.cmd ||
			    got.value !== exp_r.value || got.sig !== exp_r.sig) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t mismatch: expected slot=%0d cmd=%02h value=%04h sig=%0d",
						$realtime, exp_r.slot, exp_r.cmd, exp_r.value, $signed(exp_r.sig));
					$display("%0t          actual   slot=%0d cmd=%02h value=%04h sig=%0d",
						$realtime, got.slot, got.cmd, got.value, $signed(got.sig));
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  target_slot;
	logic [7:0]  command_code;
	logic [15:0] param_value;
	logic signed [23:0] max_signal;

	frame_scoreboard sb = new();
	bit          quiet = 1'b0;
	int unsigned idle_cycles = 0;
	int unsigned bytes_sent = 0;

	serial_frame_command_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.target_slot  (target_slot),
		.command_code (command_code),
		.param_value  (param_value),
		.max_signal   (max_signal)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// One byte transaction; called at a falling edge, returns at one
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (in_stall);
		sb.take_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Header, length, then payload with command and value at their positions
	task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
	                          input logic [15:0] value);
		int         n;
		int         i;
		logic [7:0] b;
		n = (len == 8'd0) ? 1 : int'(len);
		send_byte(sfcd_pkg::HDR_FIRST);
		send_byte(sfcd_pkg::HDR_SECOND);
		send_byte(len);
		for (i = 0; i < n; i++) begin
			case (i)
				sfcd_pkg::CMD_POS:    b = cmd;
				sfcd_pkg::VAL_HI_POS: b = value[15:8];
				sfcd_pkg::VAL_LO_POS: b = value[7:0];
				default:              b = 8'($urandom_range(0, 255));
			endcase
			send_byte(b);
		end
	endtask

	task automatic drain_results();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Result stalls in random bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Result check and watchdog on accepted transactions
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result({target_slot, command_code, param_value, max_signal});
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0]  dir_cmds [17];
		logic [7:0]  len;
		logic [7:0]  cmd;
		logic [15:0] value;
		logic [7:0]  b;
		int unsigned rand_start;
		int unsigned frames_start;
		int unsigned pick;
		int          k;
		bit          paused;

		dir_cmds = '{8'h01, 8'h03, 8'h05, 8'h07, 8'h09, 8'h0B, 8'h0D, 8'h17, 8'h19,
		             8'h1A, 8'h1B, 8'h23, 8'h28, 8'h22, 8'h29, 8'h00, 8'hFF};
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero length right after reset: decodes the reset store contents
		send_frame(8'd0, 8'h00, 16'h0000);
		// Signal count at both value extremes
		send_frame(8'd6, sfcd_pkg::CMD_SLOT_FIRST, 16'h0000);
		send_frame(8'd6, sfcd_pkg::CMD_SLOT_FIRST, 16'hFFFF);
		// Every command class and the range borders
		foreach (dir_cmds[i])
			send_frame(8'd6, dir_cmds[i], 16'($urandom_range(0, 65535)));
		// Short frame keeps the earlier value bytes
		send_frame(8'd3, sfcd_pkg::CMD_SLOT_FIRST, 16'h0000);
		// Wrong second header byte, itself a first header byte, is not a new start
		send_byte(sfcd_pkg::HDR_FIRST);
		send_byte(sfcd_pkg::HDR_FIRST);
		send_byte(sfcd_pkg::HDR_SECOND);
		send_byte(8'h00);
		send_byte(sfcd_pkg::HDR_FIRST);
		send_byte(8'h00);
		send_frame(8'd6, 8'h05, 16'h1234);
		// Overlong frames drop bytes past the store
		send_frame(8'd40, sfcd_pkg::CMD_SLOT_FIRST, 16'h8000);
		send_frame(8'd24, 8'h0B, 16'h00FF);
		// Sender holds off until all results are out
		drain_results();

		rand_start = bytes_sent;
		frames_start = sb.frames_seen;
		paused = 1'b0;
		while (bytes_sent - rand_start < RAND_BYTES ||
		       sb.frames_seen - frames_start < RAND_FRAMES) begin
			if (bytes_sent - rand_start >= QUIET_AFTER)
				quiet = 1'b1;
			if (!paused && bytes_sent - rand_start >= RAND_BYTES / 2) begin
				paused = 1'b1;
				drain_results();
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				// line noise
				for (k = 0; k < $urandom_range(1, 4); k++)
					send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 18) begin
				// broken header
				b = 8'($urandom_range(0, 255));
				if (b == sfcd_pkg::HDR_SECOND)
					b = b ^ 8'h01;
				send_byte(sfcd_pkg::HDR_FIRST);
				send_byte(b);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					len = 8'($urandom_range(0, 5));
				else if (pick < 88)
					len = 8'($urandom_range(6, 10));
				else if (pick < 98)
					len = 8'($urandom_range(11, 40));
				else
					len = 8'($urandom_range(200, 255));
				pick = $urandom_range(0, 9);
				if (pick < 6)
					cmd = 8'(2 * $urandom_range(0, 12) + 1);
				else if (pick < 8)
					cmd = 8'($urandom_range(sfcd_pkg::CMD_MANUAL_FIRST,
					                        sfcd_pkg::CMD_MANUAL_LAST));
				else
					cmd = 8'($urandom_range(0, 255));
				pick = $urandom_range(0, 9);
				if (pick == 0)
					value = 16'h0000;
				else if (pick == 1)
					value = 16'hFFFF;
				else
					value = 16'($urandom_range(0, 65535));
				send_frame(len, cmd, value);
			end
		end
		in_valid = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
